FILE: rtl/fce_pkg.sv
// ----------------------------------------------------------------------------
// fce_pkg
// Shared widths, types and register codes for the feedback echo comb unit.
// ----------------------------------------------------------------------------
package fce_pkg;

	// Sample and coefficient formats
	localparam int SAMPLE_W = 24;            // signed Q1.23
	localparam int DECAY_W  = 16;            // unsigned Q4.12
	localparam int FRAC_W   = 12;            // fraction bits of the decay
	localparam int DELAY_W  = 16;

	// Delay line: depth is a power of two so the pointer wraps naturally
	localparam int ADDR_W    = 16;
	localparam int MAX_DELAY = 1 << ADDR_W;

	// Samples-since-start counter, saturating
	localparam int             CNT_W     = 16;
	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_DELAY_LENGTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY_FACTOR = 1'b1;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic        [DECAY_W-1:0]  decay_t;
	typedef logic        [DELAY_W-1:0]  delay_t;
	typedef logic        [ADDR_W-1:0]   addr_t;
	typedef logic        [CNT_W-1:0]    count_t;

	// Control that travels with a sample into the mixing stage
	typedef struct packed {
		logic fb_en;      // warm-up over, apply feedback
		logic zero_dly;   // feedback taken from the current input
	} mix_ctl_t;

endpackage

FILE: rtl/feedback_echo_comb_unit.sv
// ----------------------------------------------------------------------------
// feedback_echo_comb_unit
// Streaming feedback comb echo with a 64K-sample delay-line memory.
// ----------------------------------------------------------------------------
// Takes one sample per clock while the result side is not stalled and
// returns one result per sample; the rate holds for every delay. At
// acceptance the delay line is read at the echo tap into stage 1; from there
// the feedback is scaled, added and saturated into the result register, and
// the output is written back. The write of the sample just ahead is
// forwarded, which closes the one-sample recursion (delay of one) through
// that single multiply-add stage. The result register decouples the output
// side: a new sample is taken while a finished one still waits. After reset
// and after each buffer start, the first delay_length samples pass through
// unchanged. Configure only while idle; cfg_ready is always high.
module feedback_echo_comb_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [fce_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fce_pkg::CFG_DATA_W-1:0]    cfg_data,
	// sample channel
	input  logic                              sample_valid,
	output logic                              sample_stall,
	input  fce_pkg::sample_t                  sample_in,
	input  logic                              buffer_start,
	// result channel
	output logic                              result_valid,
	input  logic                              result_stall,
	output fce_pkg::sample_t                  sample_out,
	output logic                              clipped
);
	import fce_pkg::*;

	// Configuration registers
	delay_t delay_q;
	decay_t decay_q;

	// Stream position
	addr_t  wp_q;
	count_t cnt_q;

	// Stage 1: sample waiting for its feedback
	logic     valid_s1;
	sample_t  x_s1;
	mix_ctl_t ctl_s1;
	addr_t    rd_addr_s1;
	addr_t    wr_addr_s1;
	sample_t  rdata_s1;

	// Most recent delay-line write, forwarded to the next read
	logic    fwd_valid_q;
	addr_t   fwd_addr_q;
	sample_t fwd_data_q;

	// Delay-line memory, contents undefined until written
	sample_t echo_mem [MAX_DELAY];

	logic     accept;
	logic     adv_s1;
	count_t   cnt_eff;
	mix_ctl_t ctl_in;
	addr_t    rd_addr;
	sample_t  fb;
	sample_t  y;
	logic     y_clip;

	// Configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= '0;
			decay_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DELAY_LENGTH: delay_q <= cfg_data[DELAY_W-1:0];
				REG_DECAY_FACTOR: decay_q <= cfg_data[DECAY_W-1:0];
				default:          ;
			endcase
		end
	end

	// Handshake: stage 1 moves on when the result register is free
	assign adv_s1       = !result_valid || !result_stall;
	assign sample_stall = valid_s1 && !adv_s1;
	assign accept       = sample_valid && !sample_stall;

	// Restart history on buffer start, decide warm-up, find the echo tap
	always_comb begin
		cnt_eff         = buffer_start ? '0 : cnt_q;
		ctl_in.fb_en    = (cnt_eff >= delay_q);
		ctl_in.zero_dly = (delay_q == '0);
		rd_addr         = wp_q - delay_q[ADDR_W-1:0];
	end

	// Advance write pointer and saturating sample count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			cnt_q <= '0;
		end else if (accept) begin
			wp_q  <= wp_q + addr_t'(1);
			cnt_q <= (cnt_eff == COUNT_MAX) ? cnt_eff : cnt_eff + count_t'(1);
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1       <= sample_in;
			ctl_s1     <= ctl_in;
			rd_addr_s1 <= rd_addr;
			wr_addr_s1 <= wp_q;
		end
	end

	// Delay line: read the tap at acceptance, write back each finished sample
	always_ff @(posedge clk) begin
		if (valid_s1 && adv_s1) begin
			echo_mem[wr_addr_s1] <= y;
		end
		if (accept) begin
			rdata_s1 <= echo_mem[rd_addr];
		end
	end

	// Hold the last write for a read of the same entry in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (valid_s1 && adv_s1) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv_s1) begin
			fwd_addr_q <= wr_addr_s1;
			fwd_data_q <= y;
		end
	end

	// Select the feedback source
	always_comb begin
		if (ctl_s1.zero_dly) begin
			fb = x_s1;
		end else if (fwd_valid_q && (fwd_addr_q == rd_addr_s1)) begin
			fb = fwd_data_q;
		end else begin
			fb = rdata_s1;
		end
	end

	fce_mix u_mix (
		.sample_x  (x_s1),
		.sample_fb (fb),
		.decay     (decay_q),
		.ctl       (ctl_s1),
		.sample_y  (y),
		.clip      (y_clip)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (adv_s1) begin
			result_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv_s1) begin
			sample_out <= y;
			clipped    <= y_clip;
		end
	end

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------

	// Stall only comes from a beat held in stage 1
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> valid_s1)
		else $error("input stalled with stage 1 empty");

	// An accepted beat always lands in stage 1
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted beat lost before stage 1");

	// A buffer start restarts the sample count
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && buffer_start |=> cnt_q == count_t'(1))
		else $error("sample count not restarted on buffer start");

	// A clipped result sits at a range limit
	a_clip_lim: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && clipped |->
			(sample_out == {1'b0, {(SAMPLE_W-1){1'b1}}})
			|| (sample_out == {1'b1, {(SAMPLE_W-1){1'b0}}}))
		else $error("clip flag set on an unsaturated result");

endmodule

FILE: rtl/fce_mix.sv
// ----------------------------------------------------------------------------
// fce_mix
// Feedback mixer: y = x + round(decay * fb), saturated to the sample range; y = x in warm-up.
// ----------------------------------------------------------------------------
module fce_mix (
	input  fce_pkg::sample_t sample_x,
	input  fce_pkg::sample_t sample_fb,
	input  fce_pkg::decay_t  decay,
	input  fce_pkg::mix_ctl_t ctl,
	output fce_pkg::sample_t sample_y,
	output logic             clip
);
	import fce_pkg::*;

	localparam int PROD_W   = SAMPLE_W + DECAY_W + 1;
	localparam int SCALED_W = PROD_W - FRAC_W;
	localparam int SUM_W    = SCALED_W + 1;

	localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(1) <<< (FRAC_W - 1);
	localparam logic signed [SUM_W-1:0]  SAT_MAX    = SUM_W'((1 << (SAMPLE_W - 1)) - 1);
	localparam logic signed [SUM_W-1:0]  SAT_MIN    = -SAT_MAX - SUM_W'(1);

	logic signed [DECAY_W:0]     decay_sx;
	logic signed [PROD_W-1:0]    prod;
	logic signed [PROD_W-1:0]    prod_rnd;
	logic signed [PROD_W-1:0]    prod_shr;
	logic signed [SCALED_W-1:0]  scaled;
	logic signed [SUM_W-1:0]     sum;

	// Scale the feedback: exact product, round half up, drop the fraction
	always_comb begin
		decay_sx = signed'({1'b0, decay});
		prod     = PROD_W'(decay_sx) * PROD_W'(sample_fb);
		prod_rnd = prod + ROUND_BIAS;
		prod_shr = prod_rnd >>> FRAC_W;
		scaled   = prod_shr[SCALED_W-1:0];
		sum      = SUM_W'(scaled) + SUM_W'(sample_x);
	end

	// Saturate, or pass the input through during warm-up
	always_comb begin
		sample_y = sample_x;
		clip     = 1'b0;
		if (ctl.fb_en) begin
			if (sum > SAT_MAX) begin
				sample_y = SAT_MAX[SAMPLE_W-1:0];
				clip     = 1'b1;
			end else if (sum < SAT_MIN) begin
				sample_y = SAT_MIN[SAMPLE_W-1:0];
				clip     = 1'b1;
			end else begin
				sample_y = sum[SAMPLE_W-1:0];
			end
		end
	end

endmodule

FILE: bench/fce_echo_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fce_echo_checker
// Watches the echo unit's channels, predicts every result and compares it.
// ----------------------------------------------------------------------------
// Keeps its own copy of the delay line, write pointer, samples-since-start
// count and both registers. Each accepted sample beat yields one expected
// result. Each accepted result beat is checked field by field against the
// oldest expectation. Counts go out by nonblocking assignment so the top reads
// them without a race.
module fce_echo_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [fce_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fce_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           sample_valid,
	input  logic                           sample_stall,
	input  fce_pkg::sample_t               sample_in,
	input  logic                           buffer_start,
	input  logic                           result_valid,
	input  logic                           result_stall,
	input  fce_pkg::sample_t               sample_out,
	input  logic                           clipped,
	output int                             errors,
	output int                             pending,
	output int                             results,
	output int                             echoes,
	output int                             clips
);
	import fce_pkg::*;

	localparam sample_t SAT_HI     = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam sample_t SAT_LO     = {1'b1, {(SAMPLE_W-1){1'b0}}};
	localparam longint  ROUND_HALF = longint'(1) << (FRAC_W - 1);

	typedef struct packed {
		sample_t smp;
		logic    clp;
	} echo_beat_t;

	// Shadow of the block's state
	sample_t    echo_line [MAX_DELAY];
	addr_t      wr_pos;
	count_t     since_start;
	delay_t     dly;
	decay_t     dcy;
	echo_beat_t echo_q [$];

	int n_err, n_res, n_echo, n_clip;

	always @(posedge clk or negedge arst_n) begin : watch
		sample_t    x, y, fb;
		addr_t      rd_addr;
		longint     prod, sum;
		logic       clp;
		echo_beat_t want;
		if (!arst_n) begin
			wr_pos      = '0;
			since_start = '0;
			dly         = '0;
			dcy         = '0;
			echo_q.delete();
		end else begin
			// Register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DELAY_LENGTH: dly = cfg_data;
					REG_DECAY_FACTOR: dcy = cfg_data;
					default: ;
				endcase
			end

			// Compare a result beat with the oldest expectation
			if (result_valid && !result_stall) begin
				n_res++;
				if (echo_q.size() == 0) begin
					$error("result beat with nothing expected: sample_out=%0d clipped=%0b",
						sample_out, clipped);
					n_err++;
				end else begin
					want = echo_q.pop_front();
					if (sample_out !== want.smp) begin
						$error("sample_out mismatch: expected %0d, actual %0d",
							want.smp, sample_out);
						n_err++;
					end
					if (clipped !== want.clp) begin
						$error("clipped mismatch: expected %0b, actual %0b",
							want.clp, clipped);
						n_err++;
					end
				end
			end

			// Predict the result of a sample beat
			if (sample_valid && !sample_stall) begin
				x   = sample_in;
				y   = x;
				clp = 1'b0;
				if (buffer_start)
					since_start = '0;
				// Warm-up passes the input through; afterwards mix in the echo
				if (since_start >= dly) begin
					rd_addr = wr_pos - dly;
					fb      = (dly == '0) ? x : echo_line[rd_addr];
					prod    = longint'(dcy) * longint'(fb);
					sum     = longint'(x) + ((prod + ROUND_HALF) >>> FRAC_W);
					if (sum > longint'(SAT_HI)) begin
						y   = SAT_HI;
						clp = 1'b1;
					end else if (sum < longint'(SAT_LO)) begin
						y   = SAT_LO;
						clp = 1'b1;
					end else begin
						y = sample_t'(sum);
					end
					if (dly != '0)
						n_echo++;
					if (clp)
						n_clip++;
				end
				echo_line[wr_pos] = y;
				wr_pos = wr_pos + 1'b1;
				if (since_start != COUNT_MAX)
					since_start = since_start + 1'b1;
				echo_q.push_back('{smp: y, clp: clp});
			end
		end
		errors  <= n_err;
		pending <= echo_q.size();
		results <= n_res;
		echoes  <= n_echo;
		clips   <= n_clip;
	end

endmodule

FILE: bench/tb_feedback_echo_comb_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_feedback_echo_comb_unit
// Stimulus and verdict for the feedback echo comb unit.
// ----------------------------------------------------------------------------
// Drives a short directed set (extremes, zero delay doubling, rounding ties,
// saturation both ways, warm-up and buffer restarts), then random phases of
// delay and decay settings with random buffer starts and bursty idling on
// both channels. The run ends with a short delay and a back-to-back stream
// with no idling, which uses the forwarding path when the delay is one. The
// checker beside the block does all prediction and comparison.
module tb_feedback_echo_comb_unit;
	import fce_pkg::*;

	localparam sample_t PEAK_POS  = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam sample_t PEAK_NEG  = {1'b1, {(SAMPLE_W-1){1'b0}}};
	localparam int      ITEM_GOAL = 1500;
	localparam int      LONG_RUN  = 150;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  cfg_valid    = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;
	logic                  sample_valid = 1'b0;
	logic                  sample_stall;
	sample_t               sample_in    = '0;
	logic                  buffer_start = 1'b0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	sample_t               sample_out;
	logic                  clipped;

	int   errors, pending, results, echoes, clips;
	int   sent   = 0;
	int   phases = 0;
	logic idle_on = 1'b1;

	feedback_echo_comb_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_in    (sample_in),
		.buffer_start (buffer_start),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.sample_out   (sample_out),
		.clipped      (clipped)
	);

	fce_echo_checker echo_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_in    (sample_in),
		.buffer_start (buffer_start),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.sample_out   (sample_out),
		.clipped      (clipped),
		.errors       (errors),
		.pending      (pending),
		.results      (results),
		.echoes       (echoes),
		.clips        (clips)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Hard stop
	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	// Stall the result side in random bursts
	initial begin : result_idler
		int hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (!idle_on)
				hold = 0;
			else if (hold > 0)
				hold--;
			else if ($urandom_range(0, 9) == 0)
				hold = $urandom_range(1, 17);
			result_stall <= (hold > 0);
		end
	end

	function automatic sample_t pick_sample();
		sample_t s;
		case ($urandom_range(0, 9))
			0:       s = PEAK_POS;
			1:       s = PEAK_NEG;
			2:       s = sample_t'($urandom_range(0, 511)) - sample_t'(256);
			default: s = sample_t'($urandom);
		endcase
		return s;
	endfunction

	// Present one sample beat, with an optional idle burst ahead of it
	task automatic send_sample(input sample_t x, input logic bs);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample_in    <= x;
		buffer_start <= bs;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	// Drain the block, then load both registers
	task automatic set_echo(input delay_t d, input decay_t k);
		sample_valid <= 1'b0;
		while (results != sent)
			@(posedge clk);
		write_reg(REG_DELAY_LENGTH, d);
		write_reg(REG_DECAY_FACTOR, k);
		cfg_valid <= 1'b0;
		phases++;
	endtask

	initial begin : stimulus
		int     blen, k, drain;
		delay_t dly;
		decay_t dcy;
		logic   bs;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: count runs from reset, output equals input
		send_sample('0, 1'b0);
		send_sample(PEAK_POS, 1'b0);
		send_sample(PEAK_NEG, 1'b0);

		// Zero delay, unity decay: doubles the input, clips at both ends
		set_echo(16'd0, 16'h1000);
		send_sample(PEAK_POS, 1'b1);
		send_sample(PEAK_NEG, 1'b0);
		send_sample(24'sh3FFFFF, 1'b0);
		send_sample(sample_t'(-1), 1'b0);

		// Half decay: rounding ties go toward plus infinity
		set_echo(16'd0, 16'h0800);
		send_sample(sample_t'(1), 1'b0);
		send_sample(sample_t'(-1), 1'b0);
		send_sample(sample_t'(3), 1'b0);
		send_sample(sample_t'(-3), 1'b0);

		// One-sample recursion with the largest decay
		set_echo(16'd1, 16'hFFFF);
		send_sample(PEAK_POS, 1'b1);
		send_sample('0, 1'b0);
		send_sample(PEAK_NEG, 1'b0);
		send_sample('0, 1'b0);

		// Short delay with warm-up and a restart inside the buffer
		set_echo(16'd3, 16'h0C00);
		send_sample(sample_t'(1000), 1'b1);
		send_sample(sample_t'(-2000), 1'b0);
		send_sample(sample_t'(3000), 1'b0);
		send_sample('0, 1'b0);
		send_sample('0, 1'b0);
		send_sample('0, 1'b0);
		send_sample(sample_t'(5), 1'b1);
		send_sample(sample_t'(6), 1'b0);
		send_sample('0, 1'b0);
		send_sample('0, 1'b0);

		// Random phases: buffers mostly longer than the delay
		while (sent < ITEM_GOAL) begin
			case ($urandom_range(0, 9))
				0:       dly = 16'd0;
				1:       dly = 16'd1;
				2:       dly = 16'd2;
				7, 8:    dly = delay_t'($urandom_range(25, 300));
				9:       dly = delay_t'($urandom_range(301, 1200));
				default: dly = delay_t'($urandom_range(3, 24));
			endcase
			case ($urandom_range(0, 5))
				0:       dcy = 16'h0000;
				1:       dcy = 16'hFFFF;
				2:       dcy = 16'h1000;
				default: dcy = decay_t'($urandom_range(0, 16'h0F00));
			endcase
			set_echo(dly, dcy);
			blen = $urandom_range(60, 160) + 2 * int'(dly);
			for (k = 0; k < blen && sent < ITEM_GOAL; k++) begin
				if (k == 0)
					bs = ($urandom_range(0, 3) != 0);
				else
					bs = ($urandom_range(0, 2 * int'(dly) + 40) == 0);
				send_sample(pick_sample(), bs);
			end
		end

		// Short delay, no idling: back-to-back beats, forwarded when the delay is one
		idle_on = 1'b0;
		set_echo(delay_t'($urandom_range(1, 4)), decay_t'($urandom_range(0, 16'h1400)));
		send_sample(pick_sample(), 1'b1);
		for (k = 1; k < LONG_RUN; k++)
			send_sample(pick_sample(), 1'b0);

		// Drain and let any stray beat show up
		sample_valid <= 1'b0;
		drain = 0;
		while (results != sent && drain < 20000) begin
			@(posedge clk);
			drain++;
		end
		repeat (8) @(posedge clk);

		$display("ran %0d samples over %0d register settings, %0d results checked",
			sent, phases, results);
		$display("%0d results took feedback from the delay line, %0d were saturated",
			echoes, clips);
		if (errors == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

FILE: files.f
rtl/fce_pkg.sv
rtl/fce_mix.sv
rtl/feedback_echo_comb_unit.sv
bench/fce_echo_checker.sv
bench/tb_feedback_echo_comb_unit.sv
